[src/pcbs_pkg.sv]
package pcbs_pkg;

  localparam int CATEGORY_COUNT = 64;
  localparam int MAX_ITEMS      = 4096;

  localparam int CAT_W     = 6;
  localparam int PRI_W     = 32;
  localparam int ID_W      = 13;
  localparam int CAT_IDX_W = (CATEGORY_COUNT > 1) ? $clog2(CATEGORY_COUNT) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [CAT_W-1:0]        cat;
    logic                    in_table;
    logic signed [PRI_W-1:0] prio;
    logic [ID_W-1:0]         id;
    logic                    is_final;
  } item_t;

endpackage

[src/pcbs_if.sv]
interface pcbs_in_if;
  import pcbs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CAT_W-1:0]        category;
  logic signed [PRI_W-1:0] priority_req;
  logic                    final_item;

  modport source (output valid, category, priority_req, final_item, input ready);
  modport sink   (input valid, category, priority_req, final_item, output ready);
endinterface

interface pcbs_out_if;
  import pcbs_pkg::*;

  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  item_id;
  logic [CAT_W-1:0] category_out;
  logic             last_result;

  modport source (output valid, item_id, category_out, last_result, input ready);
  modport sink   (input valid, item_id, category_out, last_result, output ready);
endinterface

[src/pcbs_front.sv]
module pcbs_front (
  input  logic            clk,
  input  logic            rst_n,
  pcbs_in_if.sink         in_ch,
  input  logic            push_ready,
  output logic            push_valid,
  output pcbs_pkg::item_t push_item
);
  import pcbs_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_ITEMS);
  localparam logic [CAT_W:0]   CAT_LIMIT = (CAT_W + 1)'(CATEGORY_COUNT);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] id_cnt;
  logic             xfer;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign xfer        = in_ch.valid && push_ready;

  // arrival number saturates at the item limit
  assign id_cnt = (cnt_r < CNT_MAX) ? cnt_r + 1'b1 : cnt_r;

  always_comb begin
    push_item.cat      = in_ch.category;
    push_item.in_table = ({1'b0, in_ch.category} < CAT_LIMIT);
    push_item.prio     = in_ch.priority_req;
    push_item.id       = ID_W'(id_cnt);
    push_item.is_final = in_ch.final_item;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (xfer) begin
      cnt_nxt = in_ch.final_item ? '0 : id_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[src/pcbs_fifo.sv]
module pcbs_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  pcbs_pkg::item_t push_item,
  output logic            push_ready,
  output logic            pop_valid,
  output pcbs_pkg::item_t pop_item,
  input  logic            pop_ready
);
  import pcbs_pkg::*;

  localparam logic [FIFO_PTR_W:0] FIFO_FULL = (FIFO_PTR_W + 1)'(FIFO_DEPTH);

  item_t                 buf_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_nxt;
  logic [FIFO_PTR_W:0]   count_r;
  logic [FIFO_PTR_W:0]   count_nxt;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count_r != FIFO_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = buf_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[src/pcbs_back.sv]
module pcbs_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  pcbs_pkg::item_t q_item,
  output logic            q_pop,
  pcbs_out_if.source      out_ch
);
  import pcbs_pkg::*;

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic signed [PRI_W-1:0] prio;
    logic [ID_W-1:0]         id;
  } entry_t;

  entry_t                    mem [CATEGORY_COUNT];
  entry_t                    rd_data_r;
  entry_t                    wr_data_r;
  entry_t                    wr_data;
  entry_t                    cur;
  logic [CAT_IDX_W-1:0]      rd_addr;
  logic [CAT_IDX_W-1:0]      wr_addr_r;
  logic                      wr_valid_r;

  state_t                    state_r;
  state_t                    state_nxt;
  logic                      s1_valid_r;
  item_t                     s1_item_r;
  logic [CAT_IDX_W-1:0]      s1_idx;
  logic [CATEGORY_COUNT-1:0] occ_r;
  logic [CATEGORY_COUNT-1:0] occ_nxt;
  logic [CATEGORY_COUNT-1:0] occ_rest;
  logic [CAT_IDX_W-1:0]      scan_r;
  logic [CAT_IDX_W-1:0]      scan_nxt;
  logic                      commit;
  logic                      out_free;
  logic                      load_out;

  logic                      out_valid_r;
  logic [ID_W-1:0]           out_id_r;
  logic [CAT_W-1:0]          out_cat_r;
  logic                      out_last_r;

  assign s1_idx = s1_item_r.cat[CAT_IDX_W-1:0];

  // bypass the write made on the same edge as this read
  assign cur = (wr_valid_r && (wr_addr_r == s1_idx)) ? wr_data_r : rd_data_r;

  assign commit = s1_valid_r && s1_item_r.in_table &&
                  (!occ_r[s1_idx] || ($signed(s1_item_r.prio) > $signed(cur.prio)));

  assign wr_data.prio = s1_item_r.prio;
  assign wr_data.id   = s1_item_r.id;

  assign q_pop = q_valid && (state_r == ST_RUN) && !(s1_valid_r && s1_item_r.is_final);

  assign rd_addr  = (state_r == ST_RUN) ? q_item.cat[CAT_IDX_W-1:0] : scan_r;
  assign out_free = !out_valid_r || out_ch.ready;
  assign load_out = (state_r == ST_EMIT) && out_free;

  always_comb begin
    occ_rest         = occ_r;
    occ_rest[scan_r] = 1'b0;
  end

  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    occ_nxt   = occ_r;
    if (commit) begin
      occ_nxt[s1_idx] = 1'b1;
    end
    unique case (state_r)
      ST_RUN: begin
        if (s1_valid_r && s1_item_r.is_final) begin
          state_nxt = ST_SCAN;
          scan_nxt  = '0;
        end
      end
      ST_SCAN: begin
        if (occ_r == '0) begin
          state_nxt = ST_RUN;
        end else if (occ_r[scan_r]) begin
          state_nxt = ST_EMIT;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          occ_nxt   = occ_rest;
          scan_nxt  = scan_r + 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (commit) begin
      mem[s1_idx] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
    wr_addr_r <= s1_idx;
    wr_data_r <= wr_data;
    s1_item_r <= q_item;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_id_r   <= rd_data_r.id;
      out_cat_r  <= CAT_W'(scan_r);
      out_last_r <= (occ_rest == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      s1_valid_r  <= 1'b0;
      wr_valid_r  <= 1'b0;
      occ_r       <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s1_valid_r  <= q_pop;
      wr_valid_r  <= commit;
      occ_r       <= occ_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= load_out || (out_valid_r && !out_ch.ready);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.item_id      = out_id_r;
  assign out_ch.category_out = out_cat_r;
  assign out_ch.last_result  = out_last_r;

endmodule

[src/per_category_best_item_select.sv]
// Keeps, per category, the id of the highest-priority item (earliest arrival on a tie);
// ids count arrivals from 1 and saturate at MAX_ITEMS. Outside a drain, items are taken
// one per cycle through a four-entry queue into a two-stage read-modify-write of the
// category table, with the last write bypassed into the compare. After the item flagged
// final, the table is drained in ascending category order: categories without a winner
// are skipped, and each winner is emitted once the result register is free. The queue
// holds up to four items, then input stalls until the drain ends. Results show on the out
// channel, the last one with last_result.
module per_category_best_item_select (
  input logic        clk,
  input logic        rst_n,
  pcbs_in_if.sink    in_ch,
  pcbs_out_if.source out_ch
);
  import pcbs_pkg::*;

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  pcbs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  pcbs_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop_ready  (q_pop)
  );

  pcbs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
